>>> sv/cbc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the cartridge bank controller.
package cbc_pkg;

	// What a result beat carries.
	typedef enum logic [1:0] {
		SRC_ROM   = 2'd0,
		SRC_RAM   = 2'd1,
		SRC_OPEN  = 2'd2,
		SRC_WRITE = 2'd3
	} src_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_CTRL_TYPE   = 3'd0,
		CFG_RAM_PRESENT = 3'd1,
		CFG_LARGE_ROM   = 3'd2,
		CFG_RAM_BANKED  = 3'd3,
		CFG_ROM_MASK    = 3'd4
	} cfg_idx_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 7;
	localparam int unsigned ROM_ADDR_W = 21;

	// Bus address regions, decoded from address bits 15:13.
	localparam logic [2:0] RGN_RAM_EN   = 3'b000;
	localparam logic [2:0] RGN_LOW_BANK = 3'b001;
	localparam logic [2:0] RGN_UPPER    = 3'b010;
	localparam logic [2:0] RGN_MODE     = 3'b011;
	localparam logic [2:0] RGN_VIDEO    = 3'b100;
	localparam logic [2:0] RGN_CART_RAM = 3'b101;

	localparam logic [3:0] RAM_EN_KEY  = 4'hA;
	localparam logic [7:0] OPEN_BUS    = 8'hFF;
	localparam int unsigned RAM_BANK_BYTES = 8192;

endpackage

>>> sv/cartridge_bank_controller_unit.sv
`timescale 1ns / 1ps
// Cartridge bank controller: bank registers, address mapping and cartridge RAM.
//
// One input beat is one CPU bus access: kind (0 read, 1 write), bus_address
// and write_byte, moved when in_valid is high and in_stall is low. Every
// access gives exactly one result beat (source, rom_address, read_data),
// moved when out_valid is high and out_stall is low. ROM reads answer with
// the physical ROM byte offset; cartridge RAM reads answer with the stored
// byte; disabled or unmapped areas answer open bus 0xFF; writes answer with
// a write-done beat.
// An access is captured in an input register, mapped combinationally and lands
// in the result register. One access is taken per cycle unless out_stall holds
// a waiting result; the cartridge RAM has one write port and one registered
// read port, both used by the access leaving the input register, so bank and
// RAM updates are seen by the very next access. When out_stall is high with a
// result waiting, the input register holds its access and in_stall rises;
// nothing is dropped. Configuration is written through cfg_we/cfg_index/
// cfg_data; the user must do so only while no access is in flight, which the
// block does not enforce. Reset clears both pipeline stages and sets the bank
// registers and the configuration to their defaults. RAM contents are not
// cleared; a location must be written before it is read.
module cartridge_bank_controller_unit #(
	parameter int RAM_BANKS        = 4,
	parameter int ROM_ADDRESS_BITS = 21
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             kind,
	input  logic [15:0]                      bus_address,
	input  logic [7:0]                       write_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       source,
	output logic [cbc_pkg::ROM_ADDR_W-1:0]   rom_address,
	output logic [7:0]                       read_data,
	input  logic                             cfg_we,
	input  logic [cbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cbc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int RAM_DEPTH = RAM_BANKS * cbc_pkg::RAM_BANK_BYTES;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);
	localparam logic [cbc_pkg::ROM_ADDR_W-1:0] ROM_MASK =
		cbc_pkg::ROM_ADDR_W'((64'd1 << ROM_ADDRESS_BITS) - 64'd1);

	// Configuration
	logic       ctrl_type_q, ram_present_q, large_rom_q, ram_banked_q;
	logic [6:0] rom_bank_mask_q;

	// Bank registers
	logic       ram_enabled_q, advanced_mode_q;
	logic [6:0] low_bank_q;
	logic [1:0] upper_bits_q;

	// Input stage
	logic        valid_s1;
	logic        kind_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	// Result stage
	logic                           valid_s2;
	cbc_pkg::src_t                  src_s2;
	logic [cbc_pkg::ROM_ADDR_W-1:0] rom_s2;
	logic [7:0]                     rd_s2;
	logic [7:0]                     ram_rd_s2;

	logic [7:0] cart_ram [0:RAM_DEPTH-1];

	logic                           adv;
	logic [2:0]                     region;
	logic                           ram_on;
	logic [6:0]                     bank_lo, bank_hi;
	logic [1:0]                     ram_bank_sel, ram_bank;
	logic [14:0]                    ram_addr_full;
	logic [RAM_AW-1:0]              ram_addr;
	logic                           ram_we;
	logic [4:0]                     new_low;
	cbc_pkg::src_t                  src_d;
	logic [cbc_pkg::ROM_ADDR_W-1:0] rom_d;
	logic [7:0]                     rd_d;

	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;

	assign region = addr_s1[15:13];
	assign ram_on = ram_present_q && ram_enabled_q;

	// ROM bank for 0x0000-0x3FFF and for 0x4000-0x7FFF.
	assign bank_lo = (advanced_mode_q && large_rom_q) ?
		({upper_bits_q, 5'b0} & rom_bank_mask_q) : 7'd0;
	assign bank_hi = (large_rom_q && !ram_banked_q) ?
		(({upper_bits_q, 5'b0} | low_bank_q) & rom_bank_mask_q) : low_bank_q;

	assign ram_bank_sel = (advanced_mode_q && ram_banked_q && !large_rom_q) ?
		upper_bits_q : 2'd0;

	// The selected RAM bank wraps around the fitted bank count.
	always_comb begin
		ram_bank = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (ram_bank_sel == 2'(i)) begin
				ram_bank = 2'(i % RAM_BANKS);
			end
		end
	end

	assign ram_addr_full = {ram_bank, addr_s1[12:0]};
	assign ram_addr      = ram_addr_full[RAM_AW-1:0];

	assign ram_we = adv && kind_s1 && ctrl_type_q && (region == cbc_pkg::RGN_CART_RAM)
		&& ram_on;

	assign new_low = (data_s1[4:0] == 5'd0) ? 5'd1 : data_s1[4:0];

	always_comb begin
		src_d = cbc_pkg::SRC_OPEN;
		rom_d = '0;
		rd_d  = cbc_pkg::OPEN_BUS;
		if (kind_s1) begin
			src_d = cbc_pkg::SRC_WRITE;
			rd_d  = 8'd0;
		end else if (!ctrl_type_q) begin
			if (!addr_s1[15]) begin
				src_d = cbc_pkg::SRC_ROM;
				rom_d = {5'd0, addr_s1} & ROM_MASK;
				rd_d  = 8'd0;
			end
		end else begin
			unique case (region)
				cbc_pkg::RGN_RAM_EN, cbc_pkg::RGN_LOW_BANK: begin
					src_d = cbc_pkg::SRC_ROM;
					rom_d = {bank_lo, addr_s1[13:0]} & ROM_MASK;
					rd_d  = 8'd0;
				end
				cbc_pkg::RGN_UPPER, cbc_pkg::RGN_MODE: begin
					src_d = cbc_pkg::SRC_ROM;
					rom_d = {bank_hi, addr_s1[13:0]} & ROM_MASK;
					rd_d  = 8'd0;
				end
				cbc_pkg::RGN_CART_RAM: begin
					if (ram_on) begin
						src_d = cbc_pkg::SRC_RAM;
						rd_d  = 8'd0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_type_q     <= 1'b1;
			ram_present_q   <= 1'b0;
			large_rom_q     <= 1'b0;
			ram_banked_q    <= 1'b0;
			rom_bank_mask_q <= 7'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbc_pkg::CFG_CTRL_TYPE:   ctrl_type_q     <= cfg_data[0];
				cbc_pkg::CFG_RAM_PRESENT: ram_present_q   <= cfg_data[0];
				cbc_pkg::CFG_LARGE_ROM:   large_rom_q     <= cfg_data[0];
				cbc_pkg::CFG_RAM_BANKED:  ram_banked_q    <= cfg_data[0];
				cbc_pkg::CFG_ROM_MASK:    rom_bank_mask_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enabled_q   <= 1'b0;
			low_bank_q      <= 7'd1;
			upper_bits_q    <= 2'd0;
			advanced_mode_q <= 1'b0;
		end else if (adv && kind_s1 && ctrl_type_q) begin
			unique case (region)
				cbc_pkg::RGN_RAM_EN:   ram_enabled_q   <= (data_s1[3:0] == cbc_pkg::RAM_EN_KEY);
				cbc_pkg::RGN_LOW_BANK: low_bank_q      <= {2'd0, new_low} & rom_bank_mask_q;
				cbc_pkg::RGN_UPPER:    upper_bits_q    <= data_s1[1:0];
				cbc_pkg::RGN_MODE:     advanced_mode_q <= data_s1[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			addr_s1 <= bus_address;
			data_s1 <= write_byte;
		end
		if (adv) begin
			src_s2 <= src_d;
			rom_s2 <= rom_d;
			rd_s2  <= rd_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			cart_ram[ram_addr] <= data_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ram_rd_s2 <= cart_ram[ram_addr];
		end
	end

	assign out_valid   = valid_s2;
	assign source      = src_s2;
	assign rom_address = rom_s2;
	assign read_data   = (src_s2 == cbc_pkg::SRC_RAM) ? ram_rd_s2 : rd_s2;

endmodule

>>> sv/cbc_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the cartridge bank controller and their binding.
module cbc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [1:0]                     source,
	input logic [cbc_pkg::ROM_ADDR_W-1:0] rom_address,
	input logic [7:0]                     read_data
);

	// The input side only backs up when a finished result is held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a held result");

	// A held result beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(source)
			&& $stable(rom_address) && $stable(read_data)))
		else $error("held result beat changed");

	a_write_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && source == cbc_pkg::SRC_WRITE) |-> (rom_address == '0 && read_data == 8'd0))
		else $error("write beat carries data");

	a_open_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && source == cbc_pkg::SRC_OPEN)
			|-> (rom_address == '0 && read_data == cbc_pkg::OPEN_BUS))
		else $error("open bus beat is not 0xFF");

	a_rom_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (source == cbc_pkg::SRC_ROM || source == cbc_pkg::SRC_RAM))
			|-> (source == cbc_pkg::SRC_RAM || read_data == 8'd0))
		else $error("ROM beat carries read data");

endmodule

bind cartridge_bank_controller_unit cbc_checker u_cbc_checker (.*);
